// ===== sv/sawc_pkg.sv =====
// Shared package for the set-associative write-back cache.
// Holds default sizes, command and size codes, FSM states and control structs.
// No dependencies.
package sawc_pkg;

  localparam int LINE_OFFSET_BITS = 4;
  localparam int SET_INDEX_BITS   = 4;
  localparam int WAYS             = 4;
  localparam int MEM_ADDR_BITS    = 16;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  localparam logic [31:0] BYTE_MASK = 32'hff;
  localparam logic [31:0] HALF_MASK = 32'hffff;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRD,
    ST_TCHK,
    ST_VICT,
    ST_MRD,
    ST_MLAT,
    ST_WB,
    ST_FILL,
    ST_UPD,
    ST_BYTES,
    ST_FLCHK,
    ST_FLNEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic latch_in;
    logic scan_rd;
    logic scan_chk;
    logic pick_victim;
    logic mlat;
    logic wb_step;
    logic fill_step;
    logic upd;
    logic byte_step;
    logic fl_sel;
    logic fl_next;
    logic done_load;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic in_flush;
    logic in_err;
    logic hit_now;
    logic scan_last;
    logic need_wb;
    logic cnt_last;
    logic byte_last;
    logic fl_dirty;
    logic fl_last;
    logic is_flush;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/set_assoc_writeback_cache_core.sv =====
// Top level of the set-associative write-back cache with LRU replacement.
// Depends on sawc_pkg, sawc_ctrl and sawc_datapath.
//
// After reset the internal backing memory is cleared one byte per cycle, all of its
// 2**MEM_ADDR_BITS bytes (65536 by default); in_ready stays low until then. Each item
// is then handled alone. A hit scans the ways in turn until the match, then updates the
// tag/LRU entry, steps through the access bytes and loads the result. A miss scans all
// ways, picks a victim and fills the line byte by byte from backing memory; a dirty
// victim is first written back byte by byte. A flush checks every line in turn and
// writes back each dirty one. This pace is set by the byte-wide ports of the line and
// backing RAMs and the single read port of the tag/LRU RAM.
// A finished result waits in an output register while the next item is accepted.
module set_assoc_writeback_cache_core #(
  parameter int LINE_OFFSET_BITS = sawc_pkg::LINE_OFFSET_BITS,
  parameter int SET_INDEX_BITS   = sawc_pkg::SET_INDEX_BITS,
  parameter int WAYS             = sawc_pkg::WAYS,
  parameter int MEM_ADDR_BITS    = sawc_pkg::MEM_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [1:0]  in_access_size,
  input  logic        in_sign_extend,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_hit,
  output logic        out_wrote_back,
  output logic        out_access_error
);
  import sawc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  sawc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  sawc_datapath #(
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
    .SET_INDEX_BITS   (SET_INDEX_BITS),
    .WAYS             (WAYS),
    .MEM_ADDR_BITS    (MEM_ADDR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_command       (in_command),
    .in_address       (in_address),
    .in_access_size   (in_access_size),
    .in_sign_extend   (in_sign_extend),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_hit          (out_hit),
    .out_wrote_back   (out_wrote_back),
    .out_access_error (out_access_error)
  );
endmodule

// ===== sv/sawc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sawc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sawc_ctrl.sv =====
// Controller FSM of the cache: sequences memory clear, lookup, write-back, fill, access and flush.
// Depends on sawc_pkg.
module sawc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sawc_pkg::stat_t stat,
  output sawc_pkg::ctrl_t ctrl
);
  import sawc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.in_flush) state_nxt = ST_FLCHK;
          else if (stat.in_err) state_nxt = ST_DONE;
          else state_nxt = ST_TRD;
        end
      end
      ST_TRD:    state_nxt = ST_TCHK;
      ST_TCHK: begin
        if (stat.hit_now) state_nxt = ST_UPD;
        else if (stat.scan_last) state_nxt = ST_VICT;
        else state_nxt = ST_TRD;
      end
      ST_VICT:   state_nxt = stat.need_wb ? ST_MRD : ST_FILL;
      ST_MRD:    state_nxt = ST_MLAT;
      ST_MLAT:   state_nxt = ST_WB;
      ST_WB:     if (stat.cnt_last) state_nxt = stat.is_flush ? ST_FLNEXT : ST_FILL;
      ST_FILL:   if (stat.cnt_last) state_nxt = ST_UPD;
      ST_UPD:    state_nxt = ST_BYTES;
      ST_BYTES:  if (stat.byte_last) state_nxt = ST_DONE;
      ST_FLCHK:  state_nxt = stat.fl_dirty ? ST_MRD : ST_FLNEXT;
      ST_FLNEXT: state_nxt = stat.fl_last ? ST_DONE : ST_FLCHK;
      ST_DONE:   if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR:  ctrl.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.latch_in = in_valid;
      end
      ST_TRD:    ctrl.scan_rd = 1'b1;
      ST_TCHK:   ctrl.scan_chk = 1'b1;
      ST_VICT:   ctrl.pick_victim = 1'b1;
      ST_MLAT:   ctrl.mlat = 1'b1;
      ST_WB:     ctrl.wb_step = 1'b1;
      ST_FILL:   ctrl.fill_step = 1'b1;
      ST_UPD:    ctrl.upd = 1'b1;
      ST_BYTES:  ctrl.byte_step = 1'b1;
      ST_FLCHK:  ctrl.fl_sel = 1'b1;
      ST_FLNEXT: ctrl.fl_next = 1'b1;
      ST_DONE:   ctrl.done_load = stat.out_free;
      default:   ctrl = '0;
    endcase
  end
endmodule

// ===== sv/sawc_datapath.sv =====
// Datapath of the cache: request registers, line state, tag/LRU, line and backing RAMs.
// Depends on sawc_pkg and sawc_ram.
module sawc_datapath #(
  parameter int LINE_OFFSET_BITS = sawc_pkg::LINE_OFFSET_BITS,
  parameter int SET_INDEX_BITS   = sawc_pkg::SET_INDEX_BITS,
  parameter int WAYS             = sawc_pkg::WAYS,
  parameter int MEM_ADDR_BITS    = sawc_pkg::MEM_ADDR_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sawc_pkg::ctrl_t ctrl,
  output sawc_pkg::stat_t stat,
  input  logic [1:0]      in_command,
  input  logic [15:0]     in_address,
  input  logic [1:0]      in_access_size,
  input  logic            in_sign_extend,
  input  logic [31:0]     in_write_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_read_data,
  output logic            out_hit,
  output logic            out_wrote_back,
  output logic            out_access_error
);
  import sawc_pkg::*;

  localparam int LO     = LINE_OFFSET_BITS;
  localparam int SI     = SET_INDEX_BITS;
  localparam int AW     = MEM_ADDR_BITS;
  localparam int LS     = 1 << LO;
  localparam int NSETS  = 1 << SI;
  localparam int NLINES = NSETS * WAYS;
  localparam int LW     = NLINES > 1 ? $clog2(NLINES) : 1;
  localparam int SW     = SI > 0 ? SI : 1;
  localparam int WB     = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int TAG_W  = (AW - SI - LO) > 0 ? AW - SI - LO : 1;
  localparam int XW     = AW > 16 ? AW : 16;
  localparam int MW     = TAG_W + 32;
  localparam int DW     = LW + LO;
  localparam int CW     = LO + 1;

  // request
  logic [1:0]       cmd_r;
  logic [AW-1:0]    addr_r;
  logic [1:0]       size_r;
  logic             sext_r;
  logic [31:0]      wdata_r;
  logic [TAG_W-1:0] tag_r;
  logic [SW-1:0]    set_r;
  logic             err_r;
  // working
  logic [WB-1:0]    way_r;
  logic [LW-1:0]    tgt_r;
  logic [31:0]      min_r;
  logic [WB-1:0]    vic_r;
  logic             found_r;
  logic             wbf_r;
  logic [CW-1:0]    cnt_r;
  logic [2:0]       bcnt_r;
  logic [31:0]      rdata_r;
  logic [TAG_W-1:0] wbtag_r;
  // control state
  logic [AW-1:0]     clr_r;
  logic [NLINES-1:0] valid_r;
  logic [NLINES-1:0] dirty_r;
  logic [31:0]       clock_r;
  logic              out_valid_r;
  logic [31:0]       out_rdata_r;
  logic              out_hit_r, out_wb_r, out_err_r;

  // input decode
  logic [XW-1:0]    ax;
  logic [AW-1:0]    am;
  logic             in_flush, in_err;
  logic [TAG_W-1:0] in_tag;
  logic [SW-1:0]    in_set;

  assign ax       = XW'(in_address);
  assign am       = ax[AW-1:0];
  assign in_flush = in_command == CMD_FLUSH;
  assign in_err   = !in_flush && (in_command == CMD_BAD || in_access_size == SZ_BAD ||
                    (in_access_size == SZ_HALF && am[0]) ||
                    (in_access_size == SZ_WORD && am[1:0] != 2'd0));
  assign in_tag   = TAG_W'(32'(am) >> (SI + LO));
  assign in_set   = SW'((32'(am) >> LO) & 32'(NSETS - 1));

  // line selection
  logic [LW-1:0]    cur_line, vic_line;
  logic [WB-1:0]    first_inv, vic_way;
  logic             have_inv;
  logic [MW-1:0]    meta_rdata;
  logic [TAG_W-1:0] rd_tag;
  logic [31:0]      rd_lu;
  logic             hit_now;

  assign cur_line = LW'(int'(set_r) * WAYS + int'(way_r));

  always_comb begin
    have_inv  = 1'b0;
    first_inv = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!have_inv && !valid_r[LW'(int'(set_r) * WAYS + w)]) begin
        have_inv  = 1'b1;
        first_inv = WB'(w);
      end
    end
  end

  assign vic_way  = have_inv ? first_inv : vic_r;
  assign vic_line = LW'(int'(set_r) * WAYS + int'(vic_way));
  assign rd_tag   = meta_rdata[MW-1:32];
  assign rd_lu    = meta_rdata[31:0];
  assign hit_now  = valid_r[cur_line] && rd_tag == tag_r;

  // counters and addresses
  logic [2:0]    len;
  logic [CW-1:0] cm1;
  logic [AW-1:0] wb_base, fill_base;
  logic [LO-1:0] off, boff;
  logic [1:0]    bi;
  logic          is_read, is_write;

  always_comb begin
    case (size_r)
      SZ_BYTE: len = 3'd1;
      SZ_HALF: len = 3'd2;
      default: len = 3'd4;
    endcase
  end

  assign is_read   = cmd_r == CMD_READ;
  assign is_write  = cmd_r == CMD_WRITE;
  assign cm1       = cnt_r - CW'(1);
  assign wb_base   = AW'((32'(wbtag_r) << (SI + LO)) | (32'(set_r) << LO));
  assign fill_base = {addr_r[AW-1:LO], LO'(0)};
  assign off       = addr_r[LO-1:0];
  assign boff      = off + LO'(bcnt_r);
  assign bi        = 2'(bcnt_r - 3'd1);

  // status
  assign stat.clr_last  = clr_r == '1;
  assign stat.in_flush  = in_flush;
  assign stat.in_err    = in_err;
  assign stat.hit_now   = hit_now;
  assign stat.scan_last = way_r == WB'(WAYS - 1);
  assign stat.need_wb   = valid_r[vic_line] && dirty_r[vic_line];
  assign stat.cnt_last  = cnt_r == CW'(LS);
  assign stat.byte_last = bcnt_r == len;
  assign stat.fl_dirty  = valid_r[cur_line] && dirty_r[cur_line];
  assign stat.fl_last   = way_r == WB'(WAYS - 1) && set_r == SW'(NSETS - 1);
  assign stat.is_flush  = cmd_r == CMD_FLUSH;
  assign stat.out_free  = !out_valid_r || out_ready;

  // memories
  logic          line_we, bk_we;
  logic [DW-1:0] line_waddr, line_raddr;
  logic [7:0]    line_wdata, line_rdata, bk_wdata, bk_rdata;
  logic [AW-1:0] bk_waddr, bk_raddr;

  assign line_raddr = ctrl.byte_step ? {tgt_r, boff} : {tgt_r, cnt_r[LO-1:0]};
  assign line_we    = (ctrl.fill_step && cnt_r != '0) ||
                      (ctrl.byte_step && is_write && bcnt_r < len);
  assign line_waddr = ctrl.fill_step ? {tgt_r, cm1[LO-1:0]} : {tgt_r, boff};
  assign line_wdata = ctrl.fill_step ? bk_rdata : wdata_r[8 * bcnt_r[1:0] +: 8];

  assign bk_we    = ctrl.clr_step || (ctrl.wb_step && cnt_r != '0);
  assign bk_waddr = ctrl.clr_step ? clr_r : (wb_base | AW'(cm1[LO-1:0]));
  assign bk_wdata = ctrl.clr_step ? 8'd0 : line_rdata;
  assign bk_raddr = fill_base | AW'(cnt_r[LO-1:0]);

  sawc_ram #(.WIDTH(MW), .DEPTH(NLINES)) u_meta (
    .clk   (clk),
    .we    (ctrl.upd),
    .waddr (tgt_r),
    .wdata ({tag_r, clock_r + 32'd1}),
    .raddr (ctrl.scan_rd ? cur_line : tgt_r),
    .rdata (meta_rdata)
  );

  sawc_ram #(.WIDTH(8), .DEPTH(NLINES * LS)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  sawc_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_backing (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.clr_step) clr_r <= clr_r + AW'(1);
      if (ctrl.upd) begin
        clock_r        <= clock_r + 32'd1;
        valid_r[tgt_r] <= 1'b1;
        dirty_r[tgt_r] <= is_write || (found_r && dirty_r[tgt_r]);
      end
      if (ctrl.fl_next) begin
        valid_r[tgt_r] <= 1'b0;
        dirty_r[tgt_r] <= 1'b0;
      end
      if (ctrl.done_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload
  logic [31:0] rdata_ext;

  always_comb begin
    rdata_ext = rdata_r;
    if (sext_r && size_r == SZ_BYTE && rdata_r[7]) rdata_ext = rdata_r | ~BYTE_MASK;
    if (sext_r && size_r == SZ_HALF && rdata_r[15]) rdata_ext = rdata_r | ~HALF_MASK;
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      cmd_r   <= in_command;
      addr_r  <= am;
      size_r  <= in_access_size;
      sext_r  <= in_sign_extend;
      wdata_r <= in_write_data;
      tag_r   <= in_tag;
      set_r   <= in_flush ? '0 : in_set;
      way_r   <= '0;
      err_r   <= in_err;
      found_r <= 1'b0;
      wbf_r   <= 1'b0;
      rdata_r <= '0;
    end
    if (ctrl.scan_chk) begin
      if (way_r == '0 || rd_lu < min_r) begin
        min_r <= rd_lu;
        vic_r <= way_r;
      end
      if (hit_now) begin
        found_r <= 1'b1;
        tgt_r   <= cur_line;
      end else if (way_r != WB'(WAYS - 1)) begin
        way_r <= way_r + WB'(1);
      end
    end
    if (ctrl.pick_victim) begin
      tgt_r <= vic_line;
      cnt_r <= '0;
    end
    if (ctrl.mlat) begin
      wbtag_r <= rd_tag;
      wbf_r   <= 1'b1;
      cnt_r   <= '0;
    end
    if (ctrl.wb_step || ctrl.fill_step) begin
      cnt_r <= (cnt_r == CW'(LS)) ? '0 : cnt_r + CW'(1);
    end
    if (ctrl.upd) bcnt_r <= '0;
    if (ctrl.byte_step) begin
      bcnt_r <= bcnt_r + 3'd1;
      if (is_read && bcnt_r != 3'd0) rdata_r[8 * bi +: 8] <= line_rdata;
    end
    if (ctrl.fl_sel) tgt_r <= cur_line;
    if (ctrl.fl_next) begin
      if (way_r == WB'(WAYS - 1)) begin
        way_r <= '0;
        set_r <= set_r + SW'(1);
      end else begin
        way_r <= way_r + WB'(1);
      end
    end
    if (ctrl.done_load) begin
      out_rdata_r <= rdata_ext;
      out_hit_r   <= found_r;
      out_wb_r    <= wbf_r;
      out_err_r   <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rdata_r;
  assign out_hit          = out_hit_r;
  assign out_wrote_back   = out_wb_r;
  assign out_access_error = out_err_r;

`ifndef NO_ASSERTIONS
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.done_load && err_r |=> out_access_error && !out_hit && !out_wrote_back &&
    out_read_data == 32'd0)
    else $error("error item carries data or status");

  a_clock_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.upd |=> $stable(clock_r))
    else $error("access clock moved without an access");

  a_upd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.upd |=> valid_r[$past(tgt_r)])
    else $error("accessed line not valid");
`endif
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for set_assoc_writeback_cache_core.
// Depends on sawc_pkg; typed table rows are checked against fixed results, the rest and
// random traffic against an in-bench model of the cache, its LRU order and backing memory.
module tb;
  import sawc_pkg::*;

  localparam int LINE_BYTES = 1 << LINE_OFFSET_BITS;
  localparam int NSETS      = 1 << SET_INDEX_BITS;
  localparam int NLINES     = NSETS * WAYS;
  localparam int MEM_BYTES  = 1 << MEM_ADDR_BITS;
  localparam int N_RANDOM   = 2000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [1:0]  size;
    logic        sext;
    logic [31:0] wdata;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        hit;
    logic        wb;
    logic        err;
  } outcome_t;

  typedef struct packed {
    req_t     acc;
    logic     typed;
    outcome_t res;
  } row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_READ;
  logic [15:0] in_address = '0;
  logic [1:0]  in_access_size = SZ_BYTE;
  logic        in_sign_extend = 0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_read_data;
  logic        out_hit;
  logic        out_wrote_back;
  logic        out_access_error;

  set_assoc_writeback_cache_core u_top (.*);

  always #5 clk = ~clk;

  logic [7:0]  tag_mem   [0:NLINES-1];
  logic        valid_mem [0:NLINES-1];
  logic        dirty_mem [0:NLINES-1];
  logic [31:0] last_use  [0:NLINES-1];
  logic [31:0] use_clock;
  logic [7:0]  line_data [0:NLINES*LINE_BYTES-1];
  logic [7:0]  mem_img   [0:MEM_BYTES-1];

  outcome_t pending_q[$];
  row_t     table_rows[$];
  int       n_fail = 0, n_hits = 0, n_wb = 0, n_err = 0, n_out = 0;
  bit       quiet = 0, long_hold = 0;

  function automatic void evict_line(input int l, input int s);
    logic [15:0] base;
    base = {tag_mem[l], s[SET_INDEX_BITS-1:0], {LINE_OFFSET_BITS{1'b0}}};
    for (int i = 0; i < LINE_BYTES; i++) mem_img[base + i] = line_data[l*LINE_BYTES + i];
  endfunction

  function automatic outcome_t cache_access(input req_t a);
    outcome_t r;
    int len, off, set, l, victim, ln;
    logic [7:0] tag;
    logic found, have_inv;
    logic [15:0] base;
    r = '0;
    if (a.cmd == CMD_FLUSH) begin
      for (int s = 0; s < NSETS; s++)
        for (int w = 0; w < WAYS; w++) begin
          l = s*WAYS + w;
          if (valid_mem[l] && dirty_mem[l]) begin
            evict_line(l, s);
            r.wb = 1;
          end
          valid_mem[l] = 0;
          dirty_mem[l] = 0;
        end
    end else if (a.cmd == CMD_BAD || a.size == SZ_BAD ||
                 (a.addr & ((16'd1 << a.size) - 16'd1)) != 0) begin
      r.err = 1;
    end else begin
      len = 1 << a.size;
      off = a.addr[LINE_OFFSET_BITS-1:0];
      set = a.addr[LINE_OFFSET_BITS +: SET_INDEX_BITS];
      tag = a.addr[15 -: 8];
      found = 0;
      ln = 0;
      for (int w = 0; w < WAYS; w++) begin
        l = set*WAYS + w;
        if (!found && valid_mem[l] && tag_mem[l] == tag) begin
          found = 1;
          ln = l;
        end
      end
      if (found) r.hit = 1;
      else begin
        have_inv = 0;
        victim = 0;
        for (int w = 0; w < WAYS; w++)
          if (!have_inv && !valid_mem[set*WAYS + w]) begin
            have_inv = 1;
            victim = w;
          end
        if (!have_inv)
          for (int w = 1; w < WAYS; w++)
            if (last_use[set*WAYS + w] < last_use[set*WAYS + victim]) victim = w;
        ln = set*WAYS + victim;
        if (valid_mem[ln] && dirty_mem[ln]) begin
          evict_line(ln, set);
          r.wb = 1;
        end
        valid_mem[ln] = 1;
        dirty_mem[ln] = 0;
        tag_mem[ln] = tag;
        base = {a.addr[15:LINE_OFFSET_BITS], {LINE_OFFSET_BITS{1'b0}}};
        for (int i = 0; i < LINE_BYTES; i++) line_data[ln*LINE_BYTES + i] = mem_img[base + i];
      end
      use_clock = use_clock + 1;
      last_use[ln] = use_clock;
      if (a.cmd == CMD_READ) begin
        for (int i = 0; i < len; i++) r.rdata[8*i +: 8] = line_data[ln*LINE_BYTES + off + i];
        if (len == 1 && a.sext && r.rdata[7]) r.rdata |= ~BYTE_MASK;
        if (len == 2 && a.sext && r.rdata[15]) r.rdata |= ~HALF_MASK;
      end else begin
        for (int i = 0; i < len; i++) line_data[ln*LINE_BYTES + off + i] = a.wdata[8*i +: 8];
        dirty_mem[ln] = 1;
      end
    end
    return r;
  endfunction

  function automatic req_t random_access();
    req_t a;
    int r;
    r = $urandom_range(0, 99);
    a.cmd = r < 45 ? CMD_READ : r < 90 ? CMD_WRITE : r < 92 ? CMD_FLUSH :
            r < 95 ? CMD_BAD : CMD_READ;
    if ($urandom_range(0, 9) < 8)
      a.addr = {8'($urandom_range(0, 5)), 4'($urandom_range(0, 3)), 4'($urandom)};
    else
      a.addr = 16'($urandom);
    a.size = $urandom_range(0, 19) == 0 ? SZ_BAD : 2'($urandom_range(0, 2));
    if (a.size != SZ_BAD && $urandom_range(0, 9) != 0)
      a.addr = a.addr & ~((16'd1 << a.size) - 16'd1);
    a.sext  = 1'($urandom_range(0, 1));
    a.wdata = $urandom;
    return a;
  endfunction

  task automatic add_row(input logic [1:0] c, input logic [15:0] ad, input logic [1:0] sz,
                         input logic sx, input logic [31:0] wd, input logic typed,
                         input logic [31:0] rd, input logic h, input logic wb, input logic e);
    row_t row;
    row.acc = '{c, ad, sz, sx, wd};
    row.typed = typed;
    row.res = '{rd, h, wb, e};
    table_rows.push_back(row);
  endtask

  task automatic send(input req_t a, input logic typed, input outcome_t typed_res);
    outcome_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_command = a.cmd;
    in_address = a.addr;
    in_access_size = a.size;
    in_sign_extend = a.sext;
    in_write_data = a.wdata;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    p = cache_access(a);
    pending_q.push_back(typed ? typed_res : p);
    @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < NLINES; i++) begin
      tag_mem[i] = '0; valid_mem[i] = 0; dirty_mem[i] = 0; last_use[i] = '0;
    end
    for (int i = 0; i < NLINES*LINE_BYTES; i++) line_data[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = '0;
    use_clock = '0;

    add_row(CMD_READ,  16'h0000, SZ_WORD, 0, 0,            1, 32'h0,        0, 0, 0);
    add_row(CMD_WRITE, 16'h0000, SZ_WORD, 0, 32'hffffffff, 1, 32'h0,        1, 0, 0);
    add_row(CMD_READ,  16'h0003, SZ_BYTE, 1, 0,            1, 32'hffffffff, 1, 0, 0);
    add_row(CMD_READ,  16'h0001, SZ_BYTE, 0, 0,            1, 32'h000000ff, 1, 0, 0);
    add_row(CMD_READ,  16'h0002, SZ_HALF, 1, 0,            1, 32'hffffffff, 1, 0, 0);
    add_row(CMD_READ,  16'h0000, SZ_HALF, 0, 0,            1, 32'h0000ffff, 1, 0, 0);
    add_row(CMD_READ,  16'h0001, SZ_HALF, 0, 0,            1, 32'h0,        0, 0, 1);
    add_row(CMD_READ,  16'h0002, SZ_WORD, 0, 0,            1, 32'h0,        0, 0, 1);
    add_row(CMD_WRITE, 16'h0000, SZ_BAD,  0, 32'h1234,     1, 32'h0,        0, 0, 1);
    add_row(CMD_BAD,   16'h0000, SZ_WORD, 0, 0,            1, 32'h0,        0, 0, 1);
    add_row(CMD_WRITE, 16'hfffc, SZ_WORD, 0, 32'h80007f01, 1, 32'h0,        0, 0, 0);
    add_row(CMD_READ,  16'hfffc, SZ_WORD, 0, 0,            1, 32'h80007f01, 1, 0, 0);
    add_row(CMD_READ,  16'hfffd, SZ_BYTE, 1, 0,            1, 32'h0000007f, 1, 0, 0);
    add_row(CMD_FLUSH, 16'hffff, SZ_BAD,  1, 32'hffffffff, 1, 32'h0,        0, 1, 0);
    add_row(CMD_READ,  16'h0000, SZ_WORD, 0, 0,            1, 32'hffffffff, 0, 0, 0);
    for (int t = 1; t <= 5; t++)
      add_row(CMD_WRITE, 16'(t << 8), SZ_BYTE, 0, 32'(t), 0, 0, 0, 0, 0);
    add_row(CMD_READ,  16'h0000, SZ_WORD, 1, 0,            0, 0, 0, 0, 0);
    add_row(CMD_READ,  16'h0100, SZ_BYTE, 1, 0,            0, 0, 0, 0, 0);
    add_row(CMD_FLUSH, 16'h0000, SZ_BYTE, 0, 0,            0, 0, 0, 0, 0);

    repeat (7) @(negedge clk);
    rst_n = 1;
    foreach (table_rows[i]) send(table_rows[i].acc, table_rows[i].typed, table_rows[i].res);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 500) begin
        in_valid = 0;
        while (pending_q.size() != 0) @(negedge clk);
      end
      if (n == 1000) long_hold = 1;
      if (n == N_RANDOM - 200) quiet = 1;
      send(random_access(), 0, '0);
    end
    in_valid = 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Checked %0d results: %0d hits, %0d write-backs, %0d access errors.",
             n_out, n_hits, n_wb, n_err);
    if (n_fail == 0 && pending_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 0;
        out_ready = 0;
        repeat (400) @(negedge clk);
      end
      if (hold > 0) begin
        hold--;
        out_ready = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 13);
        out_ready = 0;
      end else out_ready = 1;
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (pending_q.size() == 0) begin
        $error("result with no expectation pending");
        n_fail++;
      end else begin
        e = pending_q.pop_front();
        if (out_read_data !== e.rdata) begin
          $error("read_data: expected %h, got %h", e.rdata, out_read_data);
          n_fail++;
        end
        if (out_hit !== e.hit) begin
          $error("hit: expected %b, got %b", e.hit, out_hit);
          n_fail++;
        end
        if (out_wrote_back !== e.wb) begin
          $error("wrote_back: expected %b, got %b", e.wb, out_wrote_back);
          n_fail++;
        end
        if (out_access_error !== e.err) begin
          $error("access_error: expected %b, got %b", e.err, out_access_error);
          n_fail++;
        end
        n_hits += e.hit;
        n_wb += e.wb;
        n_err += e.err;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
